// ----- hdl/fisheye_angular_poly_distort_assert.svh -----
// Assertion helpers for the fisheye projection checker.
// Each one expects clk and arst_n in the scope where it is used.
`ifndef FISHEYE_ANGULAR_POLY_DISTORT_ASSERT_SVH
`define FISHEYE_ANGULAR_POLY_DISTORT_ASSERT_SVH

// Check an expression at every clock edge out of reset.
`define FAPD_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("fapd check failed");

// Check that an antecedent implies a consequent sequence.
`define FAPD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("fapd check failed");

`endif

// ----- hdl/fapd_pkg.sv -----
package fapd_pkg;

	typedef logic signed [63:0] word_t;

	localparam int CORDIC_ITERS_DEF = 24;
	localparam int MUL_LAT          = 5;
	localparam int COORD_SHIFT      = 28;

	localparam word_t ANG_PI      = 64'sd3373259426;
	localparam word_t ANG_HALF_PI = 64'sd1686629713;
	localparam word_t GAIN_INV    = 64'sd652032874;
	localparam word_t ONE_Q24     = 64'sd16777216;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	// Register indexes on the write port
	localparam logic [1:0] REG_K1 = 2'd0;
	localparam logic [1:0] REG_K2 = 2'd1;
	localparam logic [1:0] REG_K3 = 2'd2;
	localparam logic [1:0] REG_K4 = 2'd3;

	localparam logic [31:0] K1_RESET = 32'd5619724;
	localparam logic [31:0] K2_RESET = 32'd1980825;
	localparam logic [31:0] K3_RESET = 32'd1546047;
	localparam logic [31:0] K4_RESET = 32'd0;

	// arctan(2^-i), truncated Q30
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic y_zero;
		logic x_zero;
		logic x_neg;
		logic y_neg;
		logic z_neg;
	} pt_flags_t;

	// Carried alongside the azimuth CORDIC
	typedef struct packed {
		pt_flags_t f;
		word_t     z;
		word_t     rspec;
	} sb_psi_t;

	// Carried alongside the radius gain product
	typedef struct packed {
		pt_flags_t f;
		word_t     z;
		word_t     rspec;
		word_t     psi;
	} sb_rg_t;

	// Carried alongside the incidence CORDIC
	typedef struct packed {
		pt_flags_t f;
		logic      r_zero;
		word_t     psi;
	} sb_th_t;

	// Carried alongside the polynomial products
	typedef struct packed {
		pt_flags_t f;
		word_t     psi;
		word_t     theta;
		word_t     t2;
	} sb_poly_t;

	// Carried alongside the rotation gain product
	typedef struct packed {
		pt_flags_t f;
		word_t     psi;
		word_t     theta_d;
	} sb_rgain_t;

	// Carried alongside the rotation CORDIC
	typedef struct packed {
		pt_flags_t f;
		word_t     theta_d;
	} sb_rot_t;

	function automatic word_t atan_q30(input int idx);
		return word_t'({32'd0, ATAN_TAB[idx]});
	endfunction

	function automatic int latency(input int iters);
		return 3 * iters + 8 * MUL_LAT + 5;
	endfunction

endpackage

// ----- hdl/fapd_mulshr.sv -----
module fapd_mulshr #(
	parameter int SHIFT = 30,
	parameter int SB_W  = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  fapd_pkg::word_t      in_a,
	input  fapd_pkg::word_t      in_b,
	input  logic [SB_W-1:0]      in_sb,
	output logic                 out_valid,
	output fapd_pkg::word_t      out_p,
	output logic [SB_W-1:0]      out_sb
);

	// Sign-magnitude product, truncated toward zero, four 32x32 partials
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	fapd_pkg::word_t a_s1, b_s1;
	logic [63:0] ua_s2, ub_s2;
	logic neg_s2, neg_s3, neg_s4;
	logic [63:0] ll_s3, lh_s3, hl_s3, hh_s3;
	logic [127:0] prod_s4;
	fapd_pkg::word_t p_s5;
	logic [SB_W-1:0] sb_s1, sb_s2, sb_s3, sb_s4, sb_s5;
	logic [63:0] mag;
	logic sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign mag = prod_s4[63+SHIFT:SHIFT];
	assign sat = |prod_s4[127:63+SHIFT];

	always_ff @(posedge clk) begin
		a_s1   <= in_a;
		b_s1   <= in_b;
		sb_s1  <= in_sb;
		ua_s2  <= a_s1[63] ? 64'(-a_s1) : 64'(a_s1);
		ub_s2  <= b_s1[63] ? 64'(-b_s1) : 64'(b_s1);
		neg_s2 <= a_s1[63] ^ b_s1[63];
		sb_s2  <= sb_s1;
		ll_s3  <= ua_s2[31:0] * ub_s2[31:0];
		lh_s3  <= ua_s2[31:0] * ub_s2[63:32];
		hl_s3  <= ua_s2[63:32] * ub_s2[31:0];
		hh_s3  <= ua_s2[63:32] * ub_s2[63:32];
		neg_s3 <= neg_s2;
		sb_s3  <= sb_s2;
		prod_s4 <= {hh_s3, 64'd0} + {32'd0, lh_s3, 32'd0} + {32'd0, hl_s3, 32'd0}
			+ {64'd0, ll_s3};
		neg_s4 <= neg_s3;
		sb_s4  <= sb_s3;
		if (sat) begin
			p_s5 <= neg_s4 ? -64'sh7FFFFFFFFFFFFFFF : 64'sh7FFFFFFFFFFFFFFF;
		end else begin
			p_s5 <= neg_s4 ? -$signed(mag) : $signed(mag);
		end
		sb_s5 <= sb_s4;
	end

	assign out_valid = v_s5;
	assign out_p     = p_s5;
	assign out_sb    = sb_s5;

endmodule

// ----- hdl/fapd_cordic_vec.sv -----
module fapd_cordic_vec #(
	parameter int ITERS = fapd_pkg::CORDIC_ITERS_DEF,
	parameter int SB_W  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fapd_pkg::word_t in_x,
	input  fapd_pkg::word_t in_y,
	input  fapd_pkg::word_t in_ang,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output fapd_pkg::word_t out_x,
	output fapd_pkg::word_t out_ang,
	output logic [SB_W-1:0] out_sb
);

	// One micro-rotation per stage; drive y to zero
	logic            v_s   [ITERS+1];
	fapd_pkg::word_t x_s   [ITERS+1];
	fapd_pkg::word_t y_s   [ITERS+1];
	fapd_pkg::word_t ang_s [ITERS+1];
	logic [SB_W-1:0] sb_s  [ITERS+1];

	assign v_s[0]   = in_valid;
	assign x_s[0]   = in_x;
	assign y_s[0]   = in_y;
	assign ang_s[0] = in_ang;
	assign sb_s[0]  = in_sb;

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[i+1] <= sb_s[i];
			if (!y_s[i][63]) begin
				x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] + fapd_pkg::atan_q30(i);
			end else begin
				x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] - fapd_pkg::atan_q30(i);
			end
		end
	end

	assign out_valid = v_s[ITERS];
	assign out_x     = x_s[ITERS];
	assign out_ang   = ang_s[ITERS];
	assign out_sb    = sb_s[ITERS];

endmodule

// ----- hdl/fapd_cordic_rot.sv -----
module fapd_cordic_rot #(
	parameter int ITERS = fapd_pkg::CORDIC_ITERS_DEF,
	parameter int SB_W  = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  fapd_pkg::word_t in_x,
	input  fapd_pkg::word_t in_ang,
	input  logic [SB_W-1:0] in_sb,
	output logic            out_valid,
	output fapd_pkg::word_t out_x,
	output fapd_pkg::word_t out_y,
	output logic [SB_W-1:0] out_sb
);

	// One micro-rotation per stage; drive the residual angle to zero
	logic            v_s   [ITERS+1];
	fapd_pkg::word_t x_s   [ITERS+1];
	fapd_pkg::word_t y_s   [ITERS+1];
	fapd_pkg::word_t ang_s [ITERS+1];
	logic [SB_W-1:0] sb_s  [ITERS+1];

	assign v_s[0]   = in_valid;
	assign x_s[0]   = in_x;
	assign y_s[0]   = '0;
	assign ang_s[0] = in_ang;
	assign sb_s[0]  = in_sb;

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[i+1] <= sb_s[i];
			if (!ang_s[i][63]) begin
				x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] - fapd_pkg::atan_q30(i);
			end else begin
				x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] + fapd_pkg::atan_q30(i);
			end
		end
	end

	assign out_valid = v_s[ITERS];
	assign out_x     = x_s[ITERS];
	assign out_y     = y_s[ITERS];
	assign out_sb    = sb_s[ITERS];

endmodule

// ----- hdl/fisheye_angular_poly_distort.sv -----
// Throughput: one item per cycle; busy is never raised, so start is always taken.
// Each result shows for one cycle under done; the receiver cannot stall it.
// Reset (arst_n low, asynchronous): all in-flight items are dropped and the
// coefficient registers return to their default values.
module fisheye_angular_poly_distort #(
	parameter int CORDIC_ITERS = fapd_pkg::CORDIC_ITERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               done,
	output logic signed [31:0] image_u,
	output logic signed [31:0] image_v,
	output logic               saturated,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [31:0]        wr_data
);

	// The pipeline runs in order, front to back:
	//   input stage   - scale to Q16.44, fold the left half plane, pick flags
	//   azimuth CORDIC (vectoring, one iteration per stage)
	//   radius gain   - remove the CORDIC gain from the vectored radius
	//   theta prep    - choose the radius, fold the rear hemisphere
	//   incidence CORDIC (vectoring)
	//   theta clamp   - hold theta inside [0, pi]
	//   polynomial    - theta^2, four Horner products, theta_d
	//   rotation gain - pre-scale theta_d by the inverse gain into Q32
	//   rotation prep - fold psi into [-pi/2, pi/2]
	//   rotation CORDIC
	//   output stage  - floor to Q24, clamp to 32 bits, flag saturation
	// Every product goes through a five-stage multiplier built of 32x32 partials.

	localparam int SB_PSI_W   = $bits(fapd_pkg::sb_psi_t);
	localparam int SB_RG_W    = $bits(fapd_pkg::sb_rg_t);
	localparam int SB_TH_W    = $bits(fapd_pkg::sb_th_t);
	localparam int SB_POLY_W  = $bits(fapd_pkg::sb_poly_t);
	localparam int SB_RGAIN_W = $bits(fapd_pkg::sb_rgain_t);
	localparam int SB_ROT_W   = $bits(fapd_pkg::sb_rot_t);

	// Never refuse an item: every stage advances every cycle
	assign busy = 1'b0;

	// ---------------- coefficient registers ----------------
	logic signed [31:0] k1_q, k2_q, k3_q, k4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= fapd_pkg::K1_RESET;
			k2_q <= fapd_pkg::K2_RESET;
			k3_q <= fapd_pkg::K3_RESET;
			k4_q <= fapd_pkg::K4_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				fapd_pkg::REG_K1: k1_q <= wr_data;
				fapd_pkg::REG_K2: k2_q <= wr_data;
				fapd_pkg::REG_K3: k3_q <= wr_data;
				fapd_pkg::REG_K4: k4_q <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	fapd_pkg::word_t    big_x, big_y, big_z;
	fapd_pkg::pt_flags_t in_flags;

	assign big_x = {{4{point_x[31]}}, point_x, 28'd0};
	assign big_y = {{4{point_y[31]}}, point_y, 28'd0};
	assign big_z = {{4{point_z[31]}}, point_z, 28'd0};

	always_comb begin
		in_flags.y_zero = (point_y == 32'sd0);
		in_flags.x_zero = (point_x == 32'sd0);
		in_flags.x_neg  = point_x[31];
		in_flags.y_neg  = point_y[31];
		in_flags.z_neg  = point_z[31];
	end

	logic                in_v_s1;
	fapd_pkg::word_t     in_px_s1, in_py_s1, in_base_s1;
	fapd_pkg::sb_psi_t   in_sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else begin
			in_v_s1 <= start && !busy;
		end
	end

	// Left half plane: turn the vector by pi so the CORDIC stays in range
	always_ff @(posedge clk) begin
		in_sb_s1.f <= in_flags;
		in_sb_s1.z <= big_z;
		if (in_flags.y_zero) begin
			in_sb_s1.rspec <= in_flags.x_neg ? -big_x : big_x;
		end else begin
			in_sb_s1.rspec <= in_flags.y_neg ? -big_y : big_y;
		end
		if (in_flags.x_neg) begin
			in_px_s1   <= -big_x;
			in_py_s1   <= -big_y;
			in_base_s1 <= (!in_flags.y_neg && !in_flags.y_zero) ?
				fapd_pkg::ANG_PI : -fapd_pkg::ANG_PI;
		end else begin
			in_px_s1   <= big_x;
			in_py_s1   <= big_y;
			in_base_s1 <= '0;
		end
	end

	// ---------------- azimuth CORDIC ----------------
	logic              psi_v;
	fapd_pkg::word_t   psi_x, psi_ang;
	logic [SB_PSI_W-1:0] psi_sb_raw;
	fapd_pkg::sb_psi_t psi_sb;

	fapd_cordic_vec #(
		.ITERS (CORDIC_ITERS),
		.SB_W  (SB_PSI_W)
	) u_psi_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_v_s1),
		.in_x      (in_px_s1),
		.in_y      (in_py_s1),
		.in_ang    (in_base_s1),
		.in_sb     (in_sb_s1),
		.out_valid (psi_v),
		.out_x     (psi_x),
		.out_ang   (psi_ang),
		.out_sb    (psi_sb_raw)
	);

	assign psi_sb = psi_sb_raw;

	// ---------------- radius gain ----------------
	fapd_pkg::sb_rg_t    rg_sb_in, rg_sb;
	logic [SB_RG_W-1:0]  rg_sb_raw;
	logic                rg_v;
	fapd_pkg::word_t     rg_r;

	always_comb begin
		rg_sb_in.f     = psi_sb.f;
		rg_sb_in.z     = psi_sb.z;
		rg_sb_in.rspec = psi_sb.rspec;
		rg_sb_in.psi   = psi_ang;
	end

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_RG_W)
	) u_radius_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (psi_v),
		.in_a      (psi_x),
		.in_b      (fapd_pkg::GAIN_INV),
		.in_sb     (rg_sb_in),
		.out_valid (rg_v),
		.out_p     (rg_r),
		.out_sb    (rg_sb_raw)
	);

	assign rg_sb = rg_sb_raw;

	// ---------------- theta prep ----------------
	fapd_pkg::word_t   radius;
	logic              thp_v_s1;
	fapd_pkg::word_t   thp_px_s1, thp_py_s1, thp_base_s1;
	fapd_pkg::sb_th_t  thp_sb_s1;

	// Axis cases keep the exact radius; the general case takes the CORDIC one
	assign radius = (rg_sb.f.y_zero || rg_sb.f.x_zero) ? rg_sb.rspec : rg_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thp_v_s1 <= 1'b0;
		end else begin
			thp_v_s1 <= rg_v;
		end
	end

	// Rear hemisphere: pre-rotate by pi/2 so theta can reach pi
	always_ff @(posedge clk) begin
		thp_sb_s1.f      <= rg_sb.f;
		thp_sb_s1.r_zero <= (radius == '0);
		thp_sb_s1.psi    <= (rg_sb.f.y_zero || rg_sb.f.x_zero) ? '0 : rg_sb.psi;
		if (rg_sb.f.z_neg) begin
			thp_px_s1   <= radius;
			thp_py_s1   <= -rg_sb.z;
			thp_base_s1 <= fapd_pkg::ANG_HALF_PI;
		end else begin
			thp_px_s1   <= rg_sb.z;
			thp_py_s1   <= radius;
			thp_base_s1 <= '0;
		end
	end

	// ---------------- incidence CORDIC ----------------
	logic               th_v;
	fapd_pkg::word_t    th_x_unused, th_ang;
	logic [SB_TH_W-1:0] th_sb_raw;
	fapd_pkg::sb_th_t   th_sb;

	fapd_cordic_vec #(
		.ITERS (CORDIC_ITERS),
		.SB_W  (SB_TH_W)
	) u_theta_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (thp_v_s1),
		.in_x      (thp_px_s1),
		.in_y      (thp_py_s1),
		.in_ang    (thp_base_s1),
		.in_sb     (thp_sb_s1),
		.out_valid (th_v),
		.out_x     (th_x_unused),
		.out_ang   (th_ang),
		.out_sb    (th_sb_raw)
	);

	assign th_sb = th_sb_raw;

	// ---------------- theta clamp ----------------
	logic                thc_v_s1;
	fapd_pkg::word_t     thc_theta_s1;
	fapd_pkg::pt_flags_t thc_f_s1;
	fapd_pkg::word_t     thc_psi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thc_v_s1 <= 1'b0;
		end else begin
			thc_v_s1 <= th_v;
		end
	end

	// On the optical axis theta is 0 in front and pi behind
	always_ff @(posedge clk) begin
		thc_f_s1   <= th_sb.f;
		thc_psi_s1 <= th_sb.psi;
		if (th_sb.r_zero) begin
			thc_theta_s1 <= th_sb.f.z_neg ? fapd_pkg::ANG_PI : '0;
		end else if (th_ang[63]) begin
			thc_theta_s1 <= '0;
		end else if (th_ang > fapd_pkg::ANG_PI) begin
			thc_theta_s1 <= fapd_pkg::ANG_PI;
		end else begin
			thc_theta_s1 <= th_ang;
		end
	end

	// ---------------- polynomial ----------------
	fapd_pkg::sb_poly_t   t2_sb_in;
	logic [SB_POLY_W-1:0] t2_sb_raw, h1_sb_raw, h2_sb_raw, h3_sb_raw, h4_sb_raw, td_sb_raw;
	fapd_pkg::sb_poly_t   t2_sb, h1_sb, h2_sb, h3_sb, h4_sb, td_sb;
	logic                 t2_v, h1_v, h2_v, h3_v, h4_v, td_v;
	fapd_pkg::word_t      t2_p, h1_p, h2_p, h3_p, h4_p, td_p;
	fapd_pkg::sb_poly_t   h1_sb_in;

	always_comb begin
		t2_sb_in.f     = thc_f_s1;
		t2_sb_in.psi   = thc_psi_s1;
		t2_sb_in.theta = thc_theta_s1;
		t2_sb_in.t2    = '0;
	end

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_theta_sq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (thc_v_s1),
		.in_a      (thc_theta_s1),
		.in_b      (thc_theta_s1),
		.in_sb     (t2_sb_in),
		.out_valid (t2_v),
		.out_p     (t2_p),
		.out_sb    (t2_sb_raw)
	);

	assign t2_sb = t2_sb_raw;

	// Attach theta^2 so that every Horner step can pick it up
	always_comb begin
		h1_sb_in    = t2_sb;
		h1_sb_in.t2 = t2_p;
	end

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_horner_k4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t2_v),
		.in_a      (64'(k4_q)),
		.in_b      (t2_p),
		.in_sb     (h1_sb_in),
		.out_valid (h1_v),
		.out_p     (h1_p),
		.out_sb    (h1_sb_raw)
	);

	assign h1_sb = h1_sb_raw;

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_horner_k3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (h1_v),
		.in_a      (64'(k3_q) + h1_p),
		.in_b      (h1_sb.t2),
		.in_sb     (h1_sb_raw),
		.out_valid (h2_v),
		.out_p     (h2_p),
		.out_sb    (h2_sb_raw)
	);

	assign h2_sb = h2_sb_raw;

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_horner_k2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (h2_v),
		.in_a      (64'(k2_q) + h2_p),
		.in_b      (h2_sb.t2),
		.in_sb     (h2_sb_raw),
		.out_valid (h3_v),
		.out_p     (h3_p),
		.out_sb    (h3_sb_raw)
	);

	assign h3_sb = h3_sb_raw;

	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_horner_k1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (h3_v),
		.in_a      (64'(k1_q) + h3_p),
		.in_b      (h3_sb.t2),
		.in_sb     (h3_sb_raw),
		.out_valid (h4_v),
		.out_p     (h4_p),
		.out_sb    (h4_sb_raw)
	);

	assign h4_sb = h4_sb_raw;

	// theta_d = theta * (1 + ...); the sum is in Q24, theta in Q30, theta_d in Q24
	fapd_mulshr #(
		.SHIFT (30),
		.SB_W  (SB_POLY_W)
	) u_theta_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (h4_v),
		.in_a      (fapd_pkg::ONE_Q24 + h4_p),
		.in_b      (h4_sb.theta),
		.in_sb     (h4_sb_raw),
		.out_valid (td_v),
		.out_p     (td_p),
		.out_sb    (td_sb_raw)
	);

	assign td_sb = td_sb_raw;

	// ---------------- rotation gain ----------------
	fapd_pkg::sb_rgain_t   rgn_sb_in, rgn_sb;
	logic [SB_RGAIN_W-1:0] rgn_sb_raw;
	logic                  rgn_v;
	fapd_pkg::word_t       rgn_x;

	always_comb begin
		rgn_sb_in.f       = td_sb.f;
		rgn_sb_in.psi     = td_sb.psi;
		rgn_sb_in.theta_d = td_p;
	end

	fapd_mulshr #(
		.SHIFT (22),
		.SB_W  (SB_RGAIN_W)
	) u_rot_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (td_v),
		.in_a      (td_p),
		.in_b      (fapd_pkg::GAIN_INV),
		.in_sb     (rgn_sb_in),
		.out_valid (rgn_v),
		.out_p     (rgn_x),
		.out_sb    (rgn_sb_raw)
	);

	assign rgn_sb = rgn_sb_raw;

	// ---------------- rotation prep ----------------
	logic              rp_v_s1;
	fapd_pkg::word_t   rp_x_s1, rp_ang_s1;
	fapd_pkg::sb_rot_t rp_sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_v_s1 <= 1'b0;
		end else begin
			rp_v_s1 <= rgn_v;
		end
	end

	// Fold psi into the CORDIC range by negating the start vector
	always_ff @(posedge clk) begin
		rp_sb_s1.f       <= rgn_sb.f;
		rp_sb_s1.theta_d <= rgn_sb.theta_d;
		if (rgn_sb.psi > fapd_pkg::ANG_HALF_PI) begin
			rp_x_s1   <= -rgn_x;
			rp_ang_s1 <= rgn_sb.psi - fapd_pkg::ANG_PI;
		end else if (rgn_sb.psi < -fapd_pkg::ANG_HALF_PI) begin
			rp_x_s1   <= -rgn_x;
			rp_ang_s1 <= rgn_sb.psi + fapd_pkg::ANG_PI;
		end else begin
			rp_x_s1   <= rgn_x;
			rp_ang_s1 <= rgn_sb.psi;
		end
	end

	// ---------------- rotation CORDIC ----------------
	logic                rot_v;
	fapd_pkg::word_t     rot_x, rot_y;
	logic [SB_ROT_W-1:0] rot_sb_raw;
	fapd_pkg::sb_rot_t   rot_sb;

	fapd_cordic_rot #(
		.ITERS (CORDIC_ITERS),
		.SB_W  (SB_ROT_W)
	) u_rot_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rp_v_s1),
		.in_x      (rp_x_s1),
		.in_ang    (rp_ang_s1),
		.in_sb     (rp_sb_s1),
		.out_valid (rot_v),
		.out_x     (rot_x),
		.out_y     (rot_y),
		.out_sb    (rot_sb_raw)
	);

	assign rot_sb = rot_sb_raw;

	// ---------------- output stage ----------------
	fapd_pkg::word_t    u_full, v_full;
	logic signed [31:0] u_clip, v_clip;
	logic               u_sat, v_sat;

	// Axis cases bypass the rotation and come out exact
	always_comb begin
		if (rot_sb.f.y_zero) begin
			u_full = rot_sb.f.x_neg ? -rot_sb.theta_d : rot_sb.theta_d;
			v_full = '0;
		end else if (rot_sb.f.x_zero) begin
			u_full = '0;
			v_full = rot_sb.f.y_neg ? -rot_sb.theta_d : rot_sb.theta_d;
		end else begin
			u_full = rot_x >>> 8;
			v_full = rot_y >>> 8;
		end
	end

	always_comb begin
		u_sat = 1'b1;
		v_sat = 1'b1;
		if (u_full > 64'(fapd_pkg::S32_MAX)) begin
			u_clip = fapd_pkg::S32_MAX;
		end else if (u_full < 64'(fapd_pkg::S32_MIN)) begin
			u_clip = fapd_pkg::S32_MIN;
		end else begin
			u_clip = u_full[31:0];
			u_sat  = 1'b0;
		end
		if (v_full > 64'(fapd_pkg::S32_MAX)) begin
			v_clip = fapd_pkg::S32_MAX;
		end else if (v_full < 64'(fapd_pkg::S32_MIN)) begin
			v_clip = fapd_pkg::S32_MIN;
		end else begin
			v_clip = v_full[31:0];
			v_sat  = 1'b0;
		end
	end

	logic               out_v_s1;
	logic signed [31:0] out_u_s1, out_v_s1_data;
	logic               out_sat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
		end else begin
			out_v_s1 <= rot_v;
		end
	end

	// Hold the last result on the ports between strobes
	always_ff @(posedge clk) begin
		if (rot_v) begin
			out_u_s1      <= u_clip;
			out_v_s1_data <= v_clip;
			out_sat_s1    <= u_sat || v_sat;
		end
	end

	assign done      = out_v_s1;
	assign image_u   = out_u_s1;
	assign image_v   = out_v_s1_data;
	assign saturated = out_sat_s1;

endmodule

// ----- hdl/fapd_checker.sv -----
`include "fisheye_angular_poly_distort_assert.svh"

module fapd_checker #(
	parameter int CORDIC_ITERS = fapd_pkg::CORDIC_ITERS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] image_u,
	input logic signed [31:0] image_v,
	input logic               saturated
);

	localparam int LAT = fapd_pkg::latency(CORDIC_ITERS);

	`FAPD_ASSERT_ALWAYS(a_never_busy, !busy)

	`FAPD_ASSERT_IMPLY(a_item_emerges, start && !busy, ##LAT done)

	`FAPD_ASSERT_IMPLY(a_no_stray_result, done, $past(start && !busy, LAT))

	`FAPD_ASSERT_IMPLY(a_sat_means_clip, done && saturated,
		(image_u == 32'sh7FFFFFFF || image_u == 32'sh80000000 ||
		 image_v == 32'sh7FFFFFFF || image_v == 32'sh80000000))

endmodule

bind fisheye_angular_poly_distort fapd_checker #(
	.CORDIC_ITERS (CORDIC_ITERS)
) u_fapd_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int LATENCY  = 3 * fapd_pkg::CORDIC_ITERS_DEF + 45;
	localparam int N_RANDOM = 1000;
	localparam longint CYCLE_LIMIT = 200000;
	localparam longint ANGLE_PI   = 64'sd3373259426;
	localparam longint ANGLE_HALF = 64'sd1686629713;
	localparam longint CORDIC_GAIN_INV = 64'sd652032874;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic               sat;
	} projection_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic               done;
	logic signed [31:0] image_u;
	logic signed [31:0] image_v;
	logic               saturated;
	logic               wr_en;
	logic [1:0]         wr_index;
	logic [31:0]        wr_data;

	// Shadow copy of the coefficient registers
	logic signed [31:0] k1_shadow, k2_shadow, k3_shadow, k4_shadow;

	projection_t pending_projections[$];
	int          mismatch_count;
	longint      cycle_count;

	fisheye_angular_poly_distort u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.done      (done),
		.image_u   (image_u),
		.image_v   (image_v),
		.saturated (saturated),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Arithmetic shift right that floors
	function automatic longint floor_shift(longint a, int s);
		return a >>> s;
	endfunction

	// Product scaled down by 2^s, magnitude truncated, held at the 64-bit maximum
	function automatic longint scaled_product(longint a, longint b, int s);
		logic        neg;
		logic [127:0] ma, mb, p, q;
		logic [63:0] r;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? 128'(-a) : 128'(a);
		mb  = (b < 0) ? 128'(-b) : 128'(b);
		ma  = {64'd0, ma[63:0]};
		mb  = {64'd0, mb[63:0]};
		p   = ma * mb;
		q   = p >> s;
		if (q[127:63] != 0)
			r = 64'h7FFFFFFFFFFFFFFF;
		else
			r = q[63:0];
		return neg ? -$signed(r) : $signed(r);
	endfunction

	function automatic longint atan_step(int i);
		return longint'({32'd0, fapd_pkg::ATAN_TAB[i]});
	endfunction

	// Vectoring: drive y to zero and return the angle swept
	function automatic longint sweep_to_axis(inout longint x, inout longint y);
		longint ang, dx, dy;
		ang = 0;
		for (int i = 0; i < fapd_pkg::CORDIC_ITERS_DEF; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; ang += atan_step(i);
			end else begin
				x -= dx; y += dy; ang -= atan_step(i);
			end
		end
		return ang;
	endfunction

	function automatic void turn_by_angle(longint mag, longint ang,
			output longint ox, output longint oy);
		longint x, y, dx, dy;
		x = mag;
		y = 0;
		if (ang > ANGLE_HALF) begin
			x = -x; ang -= ANGLE_PI;
		end else if (ang < -ANGLE_HALF) begin
			x = -x; ang += ANGLE_PI;
		end
		for (int i = 0; i < fapd_pkg::CORDIC_ITERS_DEF; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (ang >= 0) begin
				x -= dx; y += dy; ang -= atan_step(i);
			end else begin
				x += dx; y -= dy; ang += atan_step(i);
			end
		end
		ox = x;
		oy = y;
	endfunction

	function automatic logic signed [31:0] clip_word(longint a, inout logic sat);
		if (a > 64'sd2147483647) begin
			sat = 1'b1; return fapd_pkg::S32_MAX;
		end
		if (a < -64'sd2147483648) begin
			sat = 1'b1; return fapd_pkg::S32_MIN;
		end
		return a[31:0];
	endfunction

	// Project one point through the distortion polynomial
	function automatic projection_t project_point(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		longint X, Y, Z, r, psi, theta, t2, acc, theta_d, u, v, vx, vy, base, rx, ry;
		projection_t res;
		logic sat;
		X = longint'(px) <<< fapd_pkg::COORD_SHIFT;
		Y = longint'(py) <<< fapd_pkg::COORD_SHIFT;
		Z = longint'(pz) <<< fapd_pkg::COORD_SHIFT;
		psi = 0;
		sat = 1'b0;
		if (py == 0) begin
			r = X < 0 ? -X : X;
		end else if (px == 0) begin
			r = Y < 0 ? -Y : Y;
		end else begin
			vx = X; vy = Y; base = 0;
			if (vx < 0) begin
				vx = -vx; vy = -vy; base = py > 0 ? ANGLE_PI : -ANGLE_PI;
			end
			psi = base + sweep_to_axis(vx, vy);
			r = scaled_product(vx, CORDIC_GAIN_INV, 30);
		end
		if (r == 0) begin
			theta = pz >= 0 ? 0 : ANGLE_PI;
		end else begin
			vx = Z; vy = r; base = 0;
			if (Z < 0) begin
				vx = r; vy = -Z; base = ANGLE_HALF;
			end
			theta = base + sweep_to_axis(vx, vy);
			if (theta < 0) theta = 0;
			if (theta > ANGLE_PI) theta = ANGLE_PI;
		end
		t2 = scaled_product(theta, theta, 30);
		acc = longint'(k4_shadow);
		acc = longint'(k3_shadow) + scaled_product(acc, t2, 30);
		acc = longint'(k2_shadow) + scaled_product(acc, t2, 30);
		acc = longint'(k1_shadow) + scaled_product(acc, t2, 30);
		acc = (64'sd1 <<< 24) + scaled_product(acc, t2, 30);
		theta_d = scaled_product(acc, theta, 30);
		if (py == 0) begin
			u = px < 0 ? -theta_d : theta_d;
			v = 0;
		end else if (px == 0) begin
			u = 0;
			v = py < 0 ? -theta_d : theta_d;
		end else begin
			turn_by_angle(scaled_product(theta_d, CORDIC_GAIN_INV, 22), psi, rx, ry);
			u = floor_shift(rx, 8);
			v = floor_shift(ry, 8);
		end
		res.u   = clip_word(u, sat);
		res.v   = clip_word(v, sat);
		res.sat = sat;
		return res;
	endfunction

	// Cycle limit: end the run if the block stops answering
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	// Result checker: done cannot be stalled, so compare every strobe at once
	always @(posedge clk) begin
		projection_t want;
		if (arst_n && done) begin
			if (pending_projections.size() == 0) begin
				$display("%0t: unexpected item u=%0d v=%0d sat=%0b", $time,
					image_u, image_v, saturated);
				mismatch_count++;
			end else begin
				want = pending_projections.pop_front();
				if (image_u !== want.u) begin
					$display("%0t: image_u expected %0d actual %0d", $time, want.u, image_u);
					mismatch_count++;
				end
				if (image_v !== want.v) begin
					$display("%0t: image_v expected %0d actual %0d", $time, want.v, image_v);
					mismatch_count++;
				end
				if (saturated !== want.sat) begin
					$display("%0t: saturated expected %0b actual %0b", $time, want.sat,
						saturated);
					mismatch_count++;
				end
			end
		end
	end

	// Send one point, after a random gap when with_gaps is set; start stays high until the next call or end_burst
	task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, bit with_gaps);
		int gap;
		gap = with_gaps ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_projections.push_back(project_point(px, py, pz));
	endtask

	task automatic end_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for the pipeline to drain before touching the coefficients
	task automatic drain_pipeline();
		end_burst();
		while (pending_projections.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Hold the write enable high; the caller drops it after the last write
	task automatic write_coeff(logic [1:0] idx, logic signed [31:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		case (idx)
			fapd_pkg::REG_K1: k1_shadow = value;
			fapd_pkg::REG_K2: k2_shadow = value;
			fapd_pkg::REG_K3: k3_shadow = value;
			fapd_pkg::REG_K4: k4_shadow = value;
		endcase
	endtask

	task automatic load_coeffs(logic signed [31:0] a, logic signed [31:0] b,
			logic signed [31:0] c, logic signed [31:0] d);
		write_coeff(fapd_pkg::REG_K1, a);
		write_coeff(fapd_pkg::REG_K2, b);
		write_coeff(fapd_pkg::REG_K3, c);
		write_coeff(fapd_pkg::REG_K4, d);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] random_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
			2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
			default: return 32'(0);
		endcase
	endfunction

	// Axis, sign and extreme cases, reset coefficients
	task automatic test_directed_points();
		logic signed [31:0] edge_vals[6];
		edge_vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh0001_0000, -32'sh0001_0000, 1, -1};
		send_point(0, 0, 0, 0);
		send_point(0, 0, 32'sh0001_0000, 0);
		send_point(0, 0, -32'sh0001_0000, 0);
		send_point(32'sh0001_0000, 0, 32'sh0001_0000, 0);
		send_point(-32'sh0001_0000, 0, 32'sh0001_0000, 0);
		send_point(0, 32'sh0001_0000, 32'sh0001_0000, 1);
		send_point(0, -32'sh0001_0000, -32'sh0001_0000, 1);
		send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000, 0);
		send_point(-32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000, 0);
		send_point(-32'sh0003_0000, 32'sh0001_0000, 0, 1);
		send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh80000000, 0);
		foreach (edge_vals[i])
			send_point(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 3) % 6], 0);
		send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
		send_point(-1, -1, 32'sh7FFFFFFF, 0);
		drain_pipeline();
	endtask

	// Large coefficients push theta_d past the Q8.24 range
	task automatic test_saturation();
		load_coeffs(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 0);
		send_point(0, 32'sh0001_0000, -32'sh0004_0000, 1);
		send_point(-32'sh0002_0000, 0, 32'sh0001_0000, 0);
		drain_pipeline();
		load_coeffs(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_point(32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000, 0);
		send_point(0, 0, -32'sh0001_0000, 0);
		send_point(32'sh0005_0000, 32'sh0002_0000, 32'sh0001_0000, 1);
		drain_pipeline();
	endtask

	// Random points under one coefficient setting
	task automatic test_random_points(int count, bit with_gaps);
		int mode;
		logic signed [31:0] px, py, pz;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 3);
			px = random_coord(mode == 3 ? $urandom_range(0, 3) : mode);
			py = random_coord(mode == 3 ? $urandom_range(0, 3) : mode);
			pz = random_coord(mode);
			send_point(px, py, pz, with_gaps && ($urandom_range(0, 3) != 0));
		end
		drain_pipeline();
	endtask

	task automatic test_random_coeffs();
		load_coeffs($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000,
			$signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000,
			$signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
			$urandom);
		test_random_points(N_RANDOM / 5, 1);
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		point_x  = '0;
		point_y  = '0;
		point_z  = '0;
		wr_en    = 1'b0;
		wr_index = fapd_pkg::REG_K1;
		wr_data  = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		k1_shadow = fapd_pkg::K1_RESET;
		k2_shadow = fapd_pkg::K2_RESET;
		k3_shadow = fapd_pkg::K3_RESET;
		k4_shadow = fapd_pkg::K4_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_points();
		test_saturation();
		load_coeffs(fapd_pkg::K1_RESET, fapd_pkg::K2_RESET, fapd_pkg::K3_RESET,
			fapd_pkg::K4_RESET);
		// Back to back with no gaps, then with random gaps
		test_random_points(N_RANDOM / 5, 0);
		test_random_points(N_RANDOM / 5, 1);
		repeat (3) test_random_coeffs();
		load_coeffs(0, 0, 0, 0);
		test_random_points(40, 1);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
